[src/ihs_pkg.sv]
// ----------------------------------------------------------------------------
// Image header size scanner package
// Shared constants and types for the scanner top level and its parser.
// ----------------------------------------------------------------------------
package ihs_pkg;

  // image_format register codes
  localparam logic [1:0] FMT_NONE = 2'd0;
  localparam logic [1:0] FMT_PNG  = 2'd1;
  localparam logic [1:0] FMT_JPEG = 2'd2;

  localparam int unsigned DIM_W = 32;

  // JPEG byte codes
  localparam logic [7:0] JPG_MARK = 8'hff;
  localparam logic [7:0] JPG_SOI  = 8'hd8;
  localparam logic [7:0] JPG_SOF0 = 8'hc0;

  // PNG header offsets of the width and height fields
  localparam logic [4:0] PNG_WIDTH_POS  = 5'd16;
  localparam logic [4:0] PNG_HEIGHT_POS = 5'd20;
  localparam logic [4:0] PNG_END_POS    = 5'd24;

  typedef struct packed {
    logic [DIM_W-1:0] height;
    logic [DIM_W-1:0] width;
  } dims_t;

endpackage

[src/ihs_parser.sv]
// ----------------------------------------------------------------------------
// Image header parser
// Holds the scan state and updates it by one file byte per step.
// ----------------------------------------------------------------------------
module ihs_parser (
  input  logic          clk,
  input  logic          rst,
  input  logic          step,
  input  logic [7:0]    data_byte,
  input  logic          end_of_file,
  input  logic [1:0]    image_format,
  output ihs_pkg::dims_t dims
);
  import ihs_pkg::*;

  typedef enum logic [3:0] {
    PH_START, PH_SOI2, PH_MARK_FF, PH_MARKER, PH_LEN_HI,
    PH_LEN_LO, PH_SKIP, PH_SKIP_SOF, PH_DONE
  } phase_t;

  phase_t      phase, phase_next;
  logic [4:0]  byte_position, byte_position_next;
  logic [15:0] skip_remaining, skip_remaining_next;
  logic [7:0]  current_marker, current_marker_next;
  logic [7:0]  length_high, length_high_next;
  logic [DIM_W-1:0] found_width, found_width_next;
  logic [DIM_W-1:0] found_height, found_height_next;

  logic [15:0] seg_len;
  logic [15:0] skip_dec;

  assign seg_len  = {length_high, data_byte};
  assign skip_dec = skip_remaining - 16'd1;

  always_comb begin
    phase_next          = phase;
    byte_position_next  = byte_position;
    skip_remaining_next = skip_remaining;
    current_marker_next = current_marker;
    length_high_next    = length_high;
    found_width_next    = found_width;
    found_height_next   = found_height;

    case (image_format)
      FMT_PNG: begin
        if (byte_position >= PNG_WIDTH_POS && byte_position < PNG_HEIGHT_POS) begin
          found_width_next = {found_width[DIM_W-9:0], data_byte};
        end else if (byte_position >= PNG_HEIGHT_POS && byte_position < PNG_END_POS) begin
          found_height_next = {found_height[DIM_W-9:0], data_byte};
        end
        if (byte_position < PNG_END_POS) begin
          byte_position_next = byte_position + 5'd1;
        end
      end
      FMT_JPEG: begin
        case (phase)
          PH_START:   phase_next = (data_byte == JPG_MARK) ? PH_SOI2 : PH_DONE;
          PH_SOI2:    phase_next = (data_byte == JPG_SOI) ? PH_MARK_FF : PH_DONE;
          PH_MARK_FF: phase_next = (data_byte == JPG_MARK) ? PH_MARKER : PH_DONE;
          PH_MARKER: begin
            current_marker_next = data_byte;
            phase_next          = PH_LEN_HI;
          end
          PH_LEN_HI: begin
            length_high_next = data_byte;
            phase_next       = PH_LEN_LO;
          end
          PH_LEN_LO: begin
            // length covers its own two bytes; shorter lengths skip nothing
            skip_remaining_next = (seg_len >= 16'd2) ? (seg_len - 16'd2) : 16'd0;
            byte_position_next  = '0;
            if (skip_remaining_next == 16'd0) begin
              phase_next = PH_MARK_FF;
            end else if (current_marker == JPG_SOF0 && skip_remaining_next >= 16'd5) begin
              phase_next = PH_SKIP_SOF;
            end else begin
              phase_next = PH_SKIP;
            end
          end
          PH_SKIP_SOF: begin
            case (byte_position)
              5'd1:    found_height_next = {16'd0, data_byte, 8'd0};
              5'd2:    found_height_next = found_height | {24'd0, data_byte};
              5'd3:    found_width_next  = {16'd0, data_byte, 8'd0};
              5'd4:    found_width_next  = found_width | {24'd0, data_byte};
              default: ;
            endcase
            if (byte_position < 5'd5) begin
              byte_position_next = byte_position + 5'd1;
            end
            skip_remaining_next = skip_dec;
            if (skip_dec == 16'd0) begin
              phase_next = PH_MARK_FF;
            end
          end
          PH_SKIP: begin
            skip_remaining_next = skip_dec;
            if (skip_dec == 16'd0) begin
              phase_next = PH_MARK_FF;
            end
          end
          default: phase_next = PH_DONE;
        endcase
      end
      default: ;
    endcase
  end

  assign dims.width  = found_width_next;
  assign dims.height = found_height_next;

  always_ff @(posedge clk) begin
    if (rst || (step && end_of_file)) begin
      phase          <= PH_START;
      byte_position  <= '0;
      skip_remaining <= '0;
      current_marker <= '0;
      length_high    <= '0;
      found_width    <= '0;
      found_height   <= '0;
    end else if (step) begin
      phase          <= phase_next;
      byte_position  <= byte_position_next;
      skip_remaining <= skip_remaining_next;
      current_marker <= current_marker_next;
      length_high    <= length_high_next;
      found_width    <= found_width_next;
      found_height   <= found_height_next;
    end
  end

endmodule

[src/image_header_size_scanner.sv]
// ----------------------------------------------------------------------------
// Image header size scanner
// Streams the bytes of one image file and reports its pixel dimensions.
// ----------------------------------------------------------------------------
// Usage:
//   cfg channel : write image_format (0 none, 1 PNG, 2 JPEG) while idle;
//                 cfg_ready is always high.
//   s_ channel  : one file byte per transaction, s_tlast on the final byte.
//   m_ channel  : one transaction per file, sent for the byte marked last,
//                 carrying width and height (zero where nothing was found).
// Path: a byte is taken into the input register, then parsed; for the last
//   byte the result is loaded into the result register and shown on m_tvalid.
// Throughput: one byte per cycle while no last byte waits on the result register;
//   input register and parser state update in the same cycle, which sets that rate.
// Stall: while a result waits on m_tready, non-last bytes keep flowing; a
//   last byte holds in the input register until the result register frees.
// Reset: clears the input and result valids, the parser state, and sets
//   image_format to none.
// ----------------------------------------------------------------------------
module image_header_size_scanner (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_data,    // image_format
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,     // [7:0] data_byte
  input  logic        s_tlast,     // end_of_file
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata      // [31:0] pixel_width, [63:32] pixel_height
);
  import ihs_pkg::*;

  logic [1:0] image_format;

  // input register
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;

  logic       out_free;
  logic       advance;
  dims_t      dims;

  // result register
  logic [DIM_W-1:0] res_width;
  logic [DIM_W-1:0] res_height;

  assign cfg_ready = 1'b1;

  // a last byte only moves on when the result register can take its result
  assign out_free = !m_tvalid || m_tready;
  assign advance  = in_valid && (!in_last || out_free);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_format <= FMT_NONE;
    end else if (cfg_valid && cfg_ready) begin
      image_format <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

  ihs_parser u_parser (
    .clk          (clk),
    .rst          (rst),
    .step         (advance),
    .data_byte    (in_byte),
    .end_of_file  (in_last),
    .image_format (image_format),
    .dims         (dims)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance && in_last) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (advance && in_last) begin
      res_width  <= dims.width;
      res_height <= dims.height;
    end
  end

  assign m_tdata = {res_height, res_width};

  // a parsed last byte always leaves a result behind
  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    advance && in_last |=> m_tvalid)
    else $error("last byte parsed without a result");

  // a result only appears after a last byte was parsed
  a_result_from_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !$past(m_tvalid) |-> $past(advance && in_last))
    else $error("result appeared without a last byte");

  // a held byte is never dropped from the input register
  a_input_held: assert property (@(posedge clk) disable iff (rst)
    in_valid && !advance |=> in_valid && $stable(in_byte) && $stable(in_last))
    else $error("held input byte lost");

  // a stalled result is not overwritten by the next last byte
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !(advance && in_last))
    else $error("pending result overwritten");

endmodule
